[rtl/drd_pkg.sv]
// Shared types and constants for the detection row decoder.
// Used by drd_front, drd_queue, drd_back and detection_row_decoder.
package drd_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int ONE_FX      = 1 << FRAC_BITS;
  localparam int HEADER_LEN  = 5;
  localparam int MAX_CLASSES = 256;

  localparam int VAL_W   = 32;
  localparam int SCORE_W = FRAC_BITS + 1;
  localparam int CNT_W   = 9;
  localparam int CLS_W   = 8;
  localparam int POS_W   = 9;
  localparam int INV_W   = 25;
  localparam int ORG_W   = 16;
  localparam int PAD_W   = 12;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = QPTR_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam logic [CFG_IDX_W-1:0] REG_CONF_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_ORIGIN_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_ORIGIN_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP        = 3'd7;

  typedef struct packed {
    logic [SCORE_W-1:0] conf_threshold;
    logic [CNT_W-1:0]   class_count;
    logic [INV_W-1:0]   inv_scale_x;
    logic [INV_W-1:0]   inv_scale_y;
    logic [ORG_W-1:0]   roi_origin_x;
    logic [ORG_W-1:0]   roi_origin_y;
    logic [PAD_W-1:0]   pad_left;
    logic [PAD_W-1:0]   pad_top;
  } cfg_t;

  // One finished row with a winning class, waiting for box math
  typedef struct packed {
    logic signed [VAL_W-1:0] center_x;
    logic signed [VAL_W-1:0] center_y;
    logic signed [VAL_W-1:0] box_width;
    logic signed [VAL_W-1:0] box_height;
    logic signed [VAL_W-1:0] objectness;
    logic [SCORE_W-1:0]      best_score;
    logic [CLS_W-1:0]        best_class;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/drd_front.sv]
// Front end: takes row words, captures the header and tracks the class argmax.
// Pushes one job per finished row that has a winner. Depends on drd_pkg.
module drd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  drd_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [drd_pkg::VAL_W-1:0] in_value,
  input  logic                          in_row_end,
  output logic                          job_push,
  output drd_pkg::job_t                 job
);
  import drd_pkg::*;

  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic signed [VAL_W-1:0] cx_r, cy_r, w_r, h_r, obj_r;
  logic [SCORE_W-1:0]      best_r, best_nxt;
  logic [CLS_W-1:0]        cls_r, cls_nxt;
  logic                    bv_r, bv_nxt;

  logic                    in_acc;
  logic [CNT_W-1:0]        ncls;
  logic [POS_W-1:0]        cls_idx;
  logic [SCORE_W-1:0]      score;
  logic                    in_hdr;
  logic                    upd;
  logic [SCORE_W-1:0]      best_fin;
  logic [CLS_W-1:0]        cls_fin;
  logic                    bv_fin;
  logic                    row_done;
  logic                    hdr_abort;

  always_comb begin
    in_acc = in_valid && !in_stall;
    in_hdr = (pos_r < POS_W'(HEADER_LEN));

    if (cfg.class_count == '0) begin
      ncls = CNT_W'(1);
    end else if (cfg.class_count > CNT_W'(MAX_CLASSES)) begin
      ncls = CNT_W'(MAX_CLASSES);
    end else begin
      ncls = cfg.class_count;
    end

    cls_idx = pos_r - POS_W'(HEADER_LEN);

    // scores above 1.0 clamp to 1.0
    if (in_value > $signed(VAL_W'(ONE_FX))) begin
      score = SCORE_W'(ONE_FX);
    end else begin
      score = in_value[SCORE_W-1:0];
    end

    // ">=" makes the later class win a tie
    upd = in_acc && !in_hdr && !in_value[VAL_W-1] && (!bv_r || score >= best_r);

    best_fin = upd ? score : best_r;
    cls_fin  = upd ? cls_idx[CLS_W-1:0] : cls_r;
    bv_fin   = upd || bv_r;

    row_done  = in_acc && !in_hdr
                && (in_row_end || (CNT_W'(cls_idx) + CNT_W'(1) >= ncls));
    hdr_abort = in_acc && in_hdr && in_row_end;

    pos_nxt  = pos_r;
    best_nxt = best_fin;
    cls_nxt  = cls_fin;
    bv_nxt   = bv_fin;
    if (row_done || hdr_abort) begin
      pos_nxt  = '0;
      best_nxt = '0;
      cls_nxt  = '0;
      bv_nxt   = 1'b0;
    end else if (in_acc) begin
      pos_nxt = pos_r + POS_W'(1);
    end

    job_push        = row_done && bv_fin;
    job.center_x    = cx_r;
    job.center_y    = cy_r;
    job.box_width   = w_r;
    job.box_height  = h_r;
    job.objectness  = obj_r;
    job.best_score  = best_fin;
    job.best_class  = cls_fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      best_r <= '0;
      cls_r  <= '0;
      bv_r   <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      best_r <= best_nxt;
      cls_r  <= cls_nxt;
      bv_r   <= bv_nxt;
    end
  end

  // header words, overwritten before each use
  always_ff @(posedge clk) begin
    if (in_acc) begin
      unique case (pos_r)
        POS_W'(0): cx_r  <= in_value;
        POS_W'(1): cy_r  <= in_value;
        POS_W'(2): w_r   <= in_value;
        POS_W'(3): h_r   <= in_value;
        POS_W'(4): obj_r <= in_value;
        default: ;
      endcase
    end
  end

endmodule

[rtl/drd_queue.sv]
// Small job queue between the front and back ends.
// Holds drd_pkg::job_t words; depth from drd_pkg::QDEPTH.
module drd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  drd_pkg::job_t   job_in,
  input  logic            pop,
  output drd_pkg::job_t   job_out,
  output drd_pkg::q_stat_t stat
);
  import drd_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  always_comb begin
    stat.full  = (cnt_r == QCNT_W'(QDEPTH));
    stat.empty = (cnt_r == '0);
    do_push    = push && !stat.full;
    do_pop     = pop && !stat.empty;
    wr_nxt     = do_push ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt     = do_pop ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
    job_out    = mem[rd_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= job_in;
    end
  end

endmodule

[rtl/drd_back.sv]
// Back end: confidence check and corner mapping to frame pixels, five stages.
// Pops jobs from drd_queue; the whole pipe holds while the output word stalls.
// Depends on drd_pkg.
module drd_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  drd_pkg::cfg_t                      cfg,
  input  drd_pkg::job_t                      q_job,
  input  drd_pkg::q_stat_t                   q_stat,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [drd_pkg::VAL_W-1:0]   out_left,
  output logic signed [drd_pkg::VAL_W-1:0]   out_top,
  output logic signed [drd_pkg::VAL_W-1:0]   out_right,
  output logic signed [drd_pkg::VAL_W-1:0]   out_bottom,
  output logic [drd_pkg::SCORE_W-1:0]        out_confidence,
  output logic [drd_pkg::CLS_W-1:0]          out_class_label
);
  import drd_pkg::*;

  localparam int CW    = VAL_W + 2;            // corner after x1 + w
  localparam int DW    = CW + 1;               // corner minus padding
  localparam int LO_W  = FRAC_BITS + 1;
  localparam int HI_W  = DW - LO_W;
  localparam int LOP_W = LO_W + INV_W;
  localparam int HIP_W = HI_W + INV_W + 1;
  localparam int PW    = DW + INV_W + 1;
  localparam int PRW   = SCORE_W + 1 + VAL_W;
  localparam logic signed [PW-1:0] SAT_HI = PW'(2147483647);
  localparam logic signed [PW-1:0] SAT_LO = -(PW'(2147483647)) - PW'(1);

  logic en;

  // stage 1: confidence product, corners
  logic                    v1_r;
  logic signed [PRW-1:0]   prod1_r;
  logic signed [CW-1:0]    cor1_r [4];
  logic [CLS_W-1:0]        cls1_r;
  // stage 2: threshold, confidence, offsets
  logic                    v2_r;
  logic signed [DW-1:0]    d2_r [4];
  logic [SCORE_W-1:0]      conf2_r;
  logic [CLS_W-1:0]        cls2_r;
  // stage 3: partial products
  logic                    v3_r;
  logic [LOP_W-1:0]        lo3_r [4];
  logic signed [HIP_W-1:0] hi3_r [4];
  logic [SCORE_W-1:0]      conf3_r;
  logic [CLS_W-1:0]        cls3_r;
  // stage 4: full product
  logic                    v4_r;
  logic signed [PW-1:0]    p4_r [4];
  logic [SCORE_W-1:0]      conf4_r;
  logic [CLS_W-1:0]        cls4_r;
  // stage 5: output word
  logic                    v5_r;
  logic signed [VAL_W-1:0] box5_r [4];
  logic [SCORE_W-1:0]      conf5_r;
  logic [CLS_W-1:0]        cls5_r;

  logic signed [PRW-1:0]   prod_nxt;
  logic signed [CW-1:0]    cor_nxt [4];
  logic                    keep_nxt;
  logic signed [PRW-1:0]   conf_wide;
  logic [SCORE_W-1:0]      conf_nxt;
  logic signed [DW-1:0]    d_nxt [4];
  logic [LOP_W-1:0]        lo_nxt [4];
  logic signed [HIP_W-1:0] hi_nxt [4];
  logic signed [PW-1:0]    p_nxt [4];
  logic signed [PW-1:0]    q_wide [4];
  logic signed [VAL_W-1:0] box_nxt [4];
  logic signed [DW-1:0]    pad_fx [4];
  logic [INV_W-1:0]        inv_sel [4];
  logic signed [PW-1:0]    org_fx [4];

  always_comb begin
    en    = !(v5_r && out_stall);
    q_pop = en && !q_stat.empty;

    prod_nxt = $signed({1'b0, q_job.best_score}) * q_job.objectness;
    cor_nxt[0] = CW'(q_job.center_x) - CW'(q_job.box_width >>> 1);
    cor_nxt[1] = CW'(q_job.center_y) - CW'(q_job.box_height >>> 1);
    cor_nxt[2] = cor_nxt[0] + CW'(q_job.box_width);
    cor_nxt[3] = cor_nxt[1] + CW'(q_job.box_height);

    keep_nxt  = prod1_r >= $signed(PRW'({cfg.conf_threshold, {FRAC_BITS{1'b0}}}));
    conf_wide = prod1_r >>> FRAC_BITS;
    if (conf_wide < 0) begin
      conf_nxt = '0;
    end else if (conf_wide > $signed(PRW'(ONE_FX))) begin
      conf_nxt = SCORE_W'(ONE_FX);
    end else begin
      conf_nxt = conf_wide[SCORE_W-1:0];
    end

    // even lanes are x, odd lanes are y
    for (int i = 0; i < 4; i++) begin
      if ((i % 2) == 0) begin
        pad_fx[i]  = $signed(DW'({cfg.pad_left, {FRAC_BITS{1'b0}}}));
        inv_sel[i] = cfg.inv_scale_x;
        org_fx[i]  = $signed(PW'({cfg.roi_origin_x, {FRAC_BITS{1'b0}}}));
      end else begin
        pad_fx[i]  = $signed(DW'({cfg.pad_top, {FRAC_BITS{1'b0}}}));
        inv_sel[i] = cfg.inv_scale_y;
        org_fx[i]  = $signed(PW'({cfg.roi_origin_y, {FRAC_BITS{1'b0}}}));
      end
      d_nxt[i]  = DW'(cor1_r[i]) - pad_fx[i];
      lo_nxt[i] = LOP_W'(d2_r[i][LO_W-1:0]) * LOP_W'(inv_sel[i]);
      hi_nxt[i] = $signed(d2_r[i][DW-1:LO_W]) * $signed({1'b0, inv_sel[i]});
      p_nxt[i]  = (PW'(hi3_r[i]) <<< LO_W) + $signed(PW'(lo3_r[i]));
      // arithmetic shift is the floor of the product
      q_wide[i] = (p4_r[i] >>> FRAC_BITS) + org_fx[i];
      if (q_wide[i] > SAT_HI) begin
        box_nxt[i] = SAT_HI[VAL_W-1:0];
      end else if (q_wide[i] < SAT_LO) begin
        box_nxt[i] = SAT_LO[VAL_W-1:0];
      end else begin
        box_nxt[i] = q_wide[i][VAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= !q_stat.empty;
      v2_r <= v1_r && keep_nxt;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1_r <= prod_nxt;
      cls1_r  <= q_job.best_class;
      conf2_r <= conf_nxt;
      cls2_r  <= cls1_r;
      conf3_r <= conf2_r;
      cls3_r  <= cls2_r;
      conf4_r <= conf3_r;
      cls4_r  <= cls3_r;
      conf5_r <= conf4_r;
      cls5_r  <= cls4_r;
      for (int i = 0; i < 4; i++) begin
        cor1_r[i] <= cor_nxt[i];
        d2_r[i]   <= d_nxt[i];
        lo3_r[i]  <= lo_nxt[i];
        hi3_r[i]  <= hi_nxt[i];
        p4_r[i]   <= p_nxt[i];
        box5_r[i] <= box_nxt[i];
      end
    end
  end

  assign out_valid       = v5_r;
  assign out_left        = box5_r[0];
  assign out_top         = box5_r[1];
  assign out_right       = box5_r[2];
  assign out_bottom      = box5_r[3];
  assign out_confidence  = conf5_r;
  assign out_class_label = cls5_r;

endmodule

[rtl/detection_row_decoder.sv]
// Detection row decoder: grid row words in, at most one frame-space box out.
// Top level; uses drd_pkg, drd_front, drd_queue and drd_back.
//
// Input channel (in_valid / in_stall): one Q16.16 word per cycle in row order:
// center x, center y, width, height, objectness, then class scores.
// in_row_end flags the last score; a row also ends after class_count scores.
// One word is taken every cycle while the job queue has room; in_stall rises
// only when the four-entry queue is full.
// Output channel (out_valid / out_stall): one box word per qualifying row.
// A qualifying row's job goes through the queue and then the five-stage back
// pipe (product, offset, split multiply, sum, map and clamp).
// A row is at least six words, so the back pipe is never the bottleneck.
// While a box word is out and out_stall is high, the word holds and the back
// pipe freezes; the front keeps taking words until the queue fills.
// Configuration (cfg_valid / cfg_ready, always ready) writes a register by
// index; write only while the block is idle.
// Reset (rst_n, synchronous, active low) empties the queue and pipe, restarts
// the row and loads the register defaults.
module detection_row_decoder (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [drd_pkg::VAL_W-1:0]      in_value,
  input  logic                                  in_row_end,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [drd_pkg::VAL_W-1:0]      out_left,
  output logic signed [drd_pkg::VAL_W-1:0]      out_top,
  output logic signed [drd_pkg::VAL_W-1:0]      out_right,
  output logic signed [drd_pkg::VAL_W-1:0]      out_bottom,
  output logic [drd_pkg::SCORE_W-1:0]           out_confidence,
  output logic [drd_pkg::CLS_W-1:0]             out_class_label,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [drd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [drd_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import drd_pkg::*;

  cfg_t    cfg_r;
  job_t    job_in, job_out;
  logic    job_push;
  logic    q_pop;
  q_stat_t q_stat;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.conf_threshold <= SCORE_W'(32768);
      cfg_r.class_count    <= CNT_W'(80);
      cfg_r.inv_scale_x    <= INV_W'(ONE_FX);
      cfg_r.inv_scale_y    <= INV_W'(ONE_FX);
      cfg_r.roi_origin_x   <= '0;
      cfg_r.roi_origin_y   <= '0;
      cfg_r.pad_left       <= '0;
      cfg_r.pad_top        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CONF_THRESHOLD: cfg_r.conf_threshold <= cfg_data[SCORE_W-1:0];
        REG_CLASS_COUNT:    cfg_r.class_count    <= cfg_data[CNT_W-1:0];
        REG_INV_SCALE_X:    cfg_r.inv_scale_x    <= cfg_data[INV_W-1:0];
        REG_INV_SCALE_Y:    cfg_r.inv_scale_y    <= cfg_data[INV_W-1:0];
        REG_ROI_ORIGIN_X:   cfg_r.roi_origin_x   <= cfg_data[ORG_W-1:0];
        REG_ROI_ORIGIN_Y:   cfg_r.roi_origin_y   <= cfg_data[ORG_W-1:0];
        REG_PAD_LEFT:       cfg_r.pad_left       <= cfg_data[PAD_W-1:0];
        REG_PAD_TOP:        cfg_r.pad_top        <= cfg_data[PAD_W-1:0];
      endcase
    end
  end

  drd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_value   (in_value),
    .in_row_end (in_row_end),
    .job_push   (job_push),
    .job        (job_in)
  );

  drd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .job_in  (job_in),
    .pop     (q_pop),
    .job_out (job_out),
    .stat    (q_stat)
  );

  drd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_job           (job_out),
    .q_stat          (q_stat),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left        (out_left),
    .out_top         (out_top),
    .out_right       (out_right),
    .out_bottom      (out_bottom),
    .out_confidence  (out_confidence),
    .out_class_label (out_class_label)
  );

`ifndef SYNTHESIS
  // front may only finish a row on a word the queue had room for
  assert property (@(posedge clk) disable iff (!rst_n) job_push |-> !q_stat.full)
    else $error("job pushed into a full queue");

  assert property (@(posedge clk) disable iff (!rst_n) !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty");

  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid |-> out_confidence <= SCORE_W'(ONE_FX))
    else $error("confidence above 1.0");

  // a stalled box must not be replaced by the frozen pipe
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid && out_stall |=> out_valid && $stable(out_class_label))
    else $error("stalled box word lost");
`endif

endmodule

[bench/detection_row_decoder_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for detection_row_decoder: grid rows in, frame-space boxes out.
// Depends on drd_pkg and the RTL; box math is predicted in-bench from scratch.
module detection_row_decoder_tb;
  import drd_pkg::*;

  localparam int     DIRECTED_LEN = 27;
  localparam int     NUM_PHASES   = 8;
  localparam int     PHASE_WORDS  = 212;
  localparam int     DRAIN_CYCLES = 24;
  localparam int     STUCK_LIMIT  = 2000;
  localparam longint SAT_HI       = 64'sd2147483647;
  localparam longint SAT_LO       = -64'sd2147483648;

  typedef struct packed {
    logic signed [VAL_W-1:0] left;
    logic signed [VAL_W-1:0] top;
    logic signed [VAL_W-1:0] right;
    logic signed [VAL_W-1:0] bottom;
    logic [SCORE_W-1:0]      confidence;
    logic [CLS_W-1:0]        class_label;
  } box_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    typed;
    box_t                    box;
  } stim_row_t;

  typedef enum logic [1:0] {RX_FLOW, RX_CHOPPY, RX_HOLD} rx_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [VAL_W-1:0] in_value = '0;
  logic in_row_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VAL_W-1:0] out_left, out_top, out_right, out_bottom;
  logic [SCORE_W-1:0] out_confidence;
  logic [CLS_W-1:0] out_class_label;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_CONF_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of the registers, at their reset values
  logic [SCORE_W-1:0] thr_q = SCORE_W'(ONE_FX / 2);
  logic [CNT_W-1:0]   cnt_q = 9'd80;
  logic [INV_W-1:0]   inv_x_q = INV_W'(ONE_FX);
  logic [INV_W-1:0]   inv_y_q = INV_W'(ONE_FX);
  logic [ORG_W-1:0]   org_x_q = '0;
  logic [ORG_W-1:0]   org_y_q = '0;
  logic [PAD_W-1:0]   pad_l_q = '0;
  logic [PAD_W-1:0]   pad_t_q = '0;

  // predictor row state
  int     row_pos;
  longint hdr_cx, hdr_cy, hdr_w, hdr_h, hdr_obj;
  longint top_score;
  int     top_class;
  bit     top_ok;

  box_t      pending_boxes[$];
  stim_row_t directed_rows[DIRECTED_LEN];
  int        failures = 0;
  int        burst_left = 0;
  int        idle_cycles = 0;
  int        rx_left = 0;
  rx_mode_e  rx_mode = RX_FLOW;
  logic      rx_quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  detection_row_decoder i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_row_end     (in_row_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_left       (out_left),
    .out_top        (out_top),
    .out_right      (out_right),
    .out_bottom     (out_bottom),
    .out_confidence (out_confidence),
    .out_class_label(out_class_label),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  function automatic void restart_row();
    row_pos = 0;
    hdr_cx = 0;
    hdr_cy = 0;
    hdr_w = 0;
    hdr_h = 0;
    hdr_obj = 0;
    top_score = 0;
    top_class = 0;
    top_ok = 1'b0;
  endfunction

  // append a box word to the expected list
  function automatic void queue_box(box_t b);
    pending_boxes.insert(pending_boxes.size(), b);
  endfunction

  // (corner - pad) * inv_scale, floored, plus ROI origin; clamp to 32 bits
  function automatic logic signed [VAL_W-1:0] to_frame(longint corner, longint pad,
                                                      longint inv, longint origin);
    longint p;
    p = ((corner - (pad <<< FRAC_BITS)) * inv) >>> FRAC_BITS;
    p = p + (origin <<< FRAC_BITS);
    if (p > SAT_HI) p = SAT_HI;
    if (p < SAT_LO) p = SAT_LO;
    return p[VAL_W-1:0];
  endfunction

  task automatic decode_word(input logic signed [VAL_W-1:0] val, input logic last,
                             output bit got, output box_t box);
    longint v, s, prod, conf, x1, y1, x2, y2;
    int n, cls;
    v = longint'(val);
    got = 1'b0;
    box = '0;
    n = int'(cnt_q);
    if (n < 1) n = 1;
    if (n > MAX_CLASSES) n = MAX_CLASSES;
    if (row_pos < HEADER_LEN) begin
      case (row_pos)
        0: hdr_cx = v;
        1: hdr_cy = v;
        2: hdr_w = v;
        3: hdr_h = v;
        default: hdr_obj = v;
      endcase
      // row_end inside the header drops the row
      if (last) restart_row();
      else row_pos++;
    end else begin
      cls = row_pos - HEADER_LEN;
      if (v >= 0) begin
        s = (v > ONE_FX) ? longint'(ONE_FX) : v;
        // >= so a later tie takes over
        if (!top_ok || s >= top_score) begin
          top_score = s;
          top_class = cls;
          top_ok = 1'b1;
        end
      end
      if (!last && cls + 1 < n) begin
        row_pos++;
      end else begin
        prod = top_score * hdr_obj;
        if (top_ok && prod >= (longint'(thr_q) <<< FRAC_BITS)) begin
          conf = prod >>> FRAC_BITS;
          if (conf < 0) conf = 0;
          if (conf > ONE_FX) conf = ONE_FX;
          x1 = hdr_cx - (hdr_w >>> 1);
          y1 = hdr_cy - (hdr_h >>> 1);
          x2 = x1 + hdr_w;
          y2 = y1 + hdr_h;
          box.left = to_frame(x1, pad_l_q, inv_x_q, org_x_q);
          box.top = to_frame(y1, pad_t_q, inv_y_q, org_y_q);
          box.right = to_frame(x2, pad_l_q, inv_x_q, org_x_q);
          box.bottom = to_frame(y2, pad_t_q, inv_y_q, org_y_q);
          box.confidence = conf[SCORE_W-1:0];
          box.class_label = top_class[CLS_W-1:0];
          got = 1'b1;
        end
        restart_row();
      end
    end
  endtask

  task automatic send_word(input logic signed [VAL_W-1:0] val, input logic last,
                           input logic typed, input box_t want);
    int gap;
    bit got;
    box_t box;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 3) : $urandom_range(4, 20);
      burst_left = ($urandom_range(0, 99) < 20) ? $urandom_range(100, 400)
                                                 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_value <= val;
    in_row_end <= last;
    do @(posedge clk); while (in_stall);
    decode_word(val, last, got, box);
    if (typed) queue_box(want);
    else if (got) queue_box(box);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CONF_THRESHOLD: thr_q = data[SCORE_W-1:0];
      REG_CLASS_COUNT:    cnt_q = data[CNT_W-1:0];
      REG_INV_SCALE_X:    inv_x_q = data[INV_W-1:0];
      REG_INV_SCALE_Y:    inv_y_q = data[INV_W-1:0];
      REG_ROI_ORIGIN_X:   org_x_q = data[ORG_W-1:0];
      REG_ROI_ORIGIN_Y:   org_y_q = data[ORG_W-1:0];
      REG_PAD_LEFT:       pad_l_q = data[PAD_W-1:0];
      default:            pad_t_q = data[PAD_W-1:0];
    endcase
  endtask

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    box_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_boxes.size() == 0) begin
        $error("box word with nothing expected: left %0d top %0d class %0d",
               out_left, out_top, out_class_label);
        failures++;
      end else begin
        want = pending_boxes.pop_front();
        check_field("left", want.left, out_left);
        check_field("top", want.top, out_top);
        check_field("right", want.right, out_right);
        check_field("bottom", want.bottom, out_bottom);
        check_field("confidence", want.confidence, out_confidence);
        check_field("class_label", want.class_label, out_class_label);
      end
    end
  end

  // receiver: free-flowing, choppy and solid-stall stretches
  always @(posedge clk) begin
    if (rx_quiet) begin
      out_stall <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 16) : $urandom_range(8, 80);
      end
      rx_left--;
      case (rx_mode)
        RX_FLOW:   out_stall <= 1'b0;
        RX_CHOPPY: out_stall <= 1'($urandom_range(0, 1));
        default:   out_stall <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STUCK_LIMIT) begin
      $display("detection_row_decoder_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int ph, sent, ne, len, pick, k;
    bit noise;
    logic end_last, w_end;
    logic signed [VAL_W-1:0] w_val;
    logic [SCORE_W-1:0] thr_r;
    logic [CNT_W-1:0] n_r;
    logic [INV_W-1:0] ix_r, iy_r;
    logic [ORG_W-1:0] ox_r, oy_r;
    logic [PAD_W-1:0] pl_r, pt_r;

    // Rows under reset settings: plain box, tie with negative and over-range
    // scores at exactly the threshold, header cut short, saturating corners
    // with clamped confidence, and a row with no non-negative score.
    directed_rows = '{
      '{32'sd655360, 1'b0, 1'b0, '0},
      '{32'sd1310720, 1'b0, 1'b0, '0},
      '{32'sd262144, 1'b0, 1'b0, '0},
      '{32'sd393216, 1'b0, 1'b0, '0},
      '{32'sd65536, 1'b0, 1'b0, '0},
      '{32'sd65536, 1'b1, 1'b1,
        '{32'sd524288, 32'sd1114112, 32'sd786432, 32'sd1507328, 17'd65536, 8'd0}},
      '{32'sd0, 1'b0, 1'b0, '0},
      '{32'sd0, 1'b0, 1'b0, '0},
      '{-32'sd3, 1'b0, 1'b0, '0},
      '{32'sd1, 1'b0, 1'b0, '0},
      '{32'sd32768, 1'b0, 1'b0, '0},
      '{-32'sd1, 1'b0, 1'b0, '0},
      '{32'sd70000, 1'b0, 1'b0, '0},
      '{32'sd65536, 1'b1, 1'b1,
        '{32'sd2, 32'sd0, -32'sd1, 32'sd1, 17'd32768, 8'd2}},
      '{32'sd12345, 1'b1, 1'b0, '0},
      '{32'h7fff_ffff, 1'b0, 1'b0, '0},
      '{32'h8000_0000, 1'b0, 1'b0, '0},
      '{32'h7fff_ffff, 1'b0, 1'b0, '0},
      '{32'h7fff_ffff, 1'b0, 1'b0, '0},
      '{32'h7fff_ffff, 1'b0, 1'b0, '0},
      '{32'sd65536, 1'b1, 1'b1,
        '{32'sh4000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'hc000_0000, 17'd65536, 8'd0}},
      '{32'sd1, 1'b0, 1'b0, '0},
      '{32'sd2, 1'b0, 1'b0, '0},
      '{32'sd3, 1'b0, 1'b0, '0},
      '{32'sd4, 1'b0, 1'b0, '0},
      '{32'sd65536, 1'b0, 1'b0, '0},
      '{-32'sd5, 1'b1, 1'b0, '0}
    };

    restart_row();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_LEN; i++)
      send_word(directed_rows[i].value, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].box);
    in_valid <= 1'b0;

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      // let everything drain before touching the registers
      rx_quiet <= 1'b1;
      while (pending_boxes.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);

      thr_r = SCORE_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, ONE_FX)
                                                   : $urandom_range(0, 3 * ONE_FX / 4));
      n_r = CNT_W'($urandom_range(1, 12));
      ix_r = INV_W'(($urandom_range(0, 9) < 7) ? $urandom_range(ONE_FX / 4, 4 * ONE_FX)
                                               : $urandom_range(1, 1 << 24));
      iy_r = INV_W'(($urandom_range(0, 9) < 7) ? $urandom_range(ONE_FX / 4, 4 * ONE_FX)
                                               : $urandom_range(1, 1 << 24));
      ox_r = ORG_W'($urandom_range(0, 65535));
      oy_r = ORG_W'($urandom_range(0, 65535));
      pl_r = PAD_W'($urandom_range(0, 4095));
      pt_r = PAD_W'($urandom_range(0, 4095));
      case (ph)
        0: begin
          thr_r = '0; n_r = 9'd1; ix_r = 25'd1; iy_r = 25'd1;
          ox_r = '0; oy_r = '0; pl_r = '0; pt_r = '0;
        end
        1: begin
          thr_r = SCORE_W'(ONE_FX); n_r = CNT_W'(MAX_CLASSES);
          ix_r = 25'd16777216; iy_r = 25'd16777216;
          ox_r = '1; oy_r = '1; pl_r = '1; pt_r = '1;
        end
        2: n_r = 9'd0;    // clamps up to one class
        3: n_r = 9'd300;  // clamps down to the class limit
        default: ;
      endcase
      cfg_write(REG_CONF_THRESHOLD, CFG_DATA_W'(thr_r));
      cfg_write(REG_CLASS_COUNT, CFG_DATA_W'(n_r));
      cfg_write(REG_INV_SCALE_X, ix_r);
      cfg_write(REG_INV_SCALE_Y, iy_r);
      cfg_write(REG_ROI_ORIGIN_X, CFG_DATA_W'(ox_r));
      cfg_write(REG_ROI_ORIGIN_Y, CFG_DATA_W'(oy_r));
      cfg_write(REG_PAD_LEFT, CFG_DATA_W'(pl_r));
      cfg_write(REG_PAD_TOP, CFG_DATA_W'(pt_r));
      cfg_valid <= 1'b0;
      rx_quiet <= 1'b0;

      ne = int'(cnt_q);
      if (ne < 1) ne = 1;
      if (ne > MAX_CLASSES) ne = MAX_CLASSES;
      sent = 0;
      while (sent < PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        noise = 1'b0;
        end_last = 1'b1;
        if (pick < 6) begin
          len = $urandom_range(1, HEADER_LEN);
        end else if (pick < 10) begin
          len = $urandom_range(1, 8);
          noise = 1'b1;
        end else if (pick < 30 || (ne > 16 && pick < 90)) begin
          len = HEADER_LEN + $urandom_range(1, (ne < 12) ? ne : 12);
        end else begin
          len = HEADER_LEN + ne;
          end_last = ($urandom_range(0, 3) != 0);
        end
        for (k = 0; k < len; k++) begin
          pick = $urandom_range(0, 99);
          w_end = (k == len - 1) ? end_last : 1'b0;
          if (noise) begin
            w_val = $urandom;
            w_end = (k == len - 1) ? 1'b1 : 1'($urandom_range(0, 1));
          end else if (k < 2) begin
            w_val = (pick < 25) ? $urandom : $urandom_range(0, 1280 * ONE_FX);
          end else if (k < 4) begin
            w_val = (pick < 25) ? $urandom : $urandom_range(0, 400 * ONE_FX);
          end else if (k == 4) begin
            if (pick < 45) w_val = ONE_FX;
            else if (pick < 80) w_val = $urandom_range(0, ONE_FX);
            else if (pick < 90) w_val = $urandom;
            else w_val = -$signed($urandom_range(0, ONE_FX));
          end else begin
            // class scores: frequent ties, some negative or above one
            if (pick < 30) begin
              case ($urandom_range(0, 2))
                0: w_val = '0;
                1: w_val = ONE_FX / 2;
                default: w_val = ONE_FX;
              endcase
            end else if (pick < 75) w_val = $urandom_range(0, ONE_FX);
            else if (pick < 85) w_val = $urandom | 32'h8000_0000;
            else if (pick < 92) w_val = $urandom_range(ONE_FX + 1, 32'h7fff_ffff);
            else w_val = $urandom;
          end
          send_word(w_val, w_end, 1'b0, '0);
          sent++;
        end
      end
      in_valid <= 1'b0;
    end

    rx_quiet <= 1'b1;
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("detection_row_decoder_tb OK");
    else
      $display("detection_row_decoder_tb NOT OK");
    $finish;
  end

endmodule
